/* rtl/mse_pkg.sv */
// Package for the merge sort engine: word type, sequencer states and fixed widths.
// Used by the channel interfaces and by merge_sort_engine_unit.
package mse_pkg;

   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_PASS,
      S_RUN,
      S_READ,
      S_MERGE,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_OUT
   } state_type;

endpackage

/* rtl/mse_req_if.sv */
// Input channel of the merge sort engine: one value per word plus the end-of-set flag.
// Depends on mse_pkg.
interface mse_req_if;
   import mse_pkg::*;

   logic     valid;
   logic     ready;
   word_type value;
   logic     last_in_set;

   modport source (output valid, output value, output last_in_set, input ready);
   modport sink   (input valid, input value, input last_in_set, output ready);
endinterface

/* rtl/mse_rsp_if.sv */
// Result channel of the merge sort engine: one sorted value per word with its flags.
// Depends on mse_pkg.
interface mse_rsp_if;
   import mse_pkg::*;

   logic     valid;
   logic     ready;
   word_type sorted_value;
   logic     last_of_run;
   logic     dropped;

   modport source (output valid, output sorted_value, output last_of_run, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_of_run, input dropped,
                   output ready);
endinterface

/* rtl/merge_sort_engine_unit.sv */
// Top level of the merge sort engine: value store, scratch memory and merge sequencer.
// Depends on mse_pkg, mse_req_if and mse_rsp_if.
//
// The block collects signed 32-bit values, one per input word, into a store of
// MAX_ITEMS entries; the word with last_in_set high closes the set. Words that
// arrive while the store is full are discarded and every result of that set
// carries dropped. The set is then sorted ascending by a bottom-up merge sort
// and the values leave one per result word, the final one with last_of_run.
// While loading, the input is ready and a word is taken whenever valid is high. For
// a set of n values the sort runs ceil(log2(n)) passes; each compare-and-move step
// reads both run heads, then compares and writes one value, each run opens with a
// setup step and each pass with a pass step, and a final pass step closes the sort.
// Emitting each value takes a memory read, an output load and the handshake. The
// pace is set by the single shared compare unit and the one write port of each
// memory. No input word is taken from the end of a set until its last result has
// been accepted.
module merge_sort_engine_unit #(
   parameter int MAX_ITEMS = 64
) (
   input logic       clock,
   input logic       reset,
   mse_req_if.sink   req_chan,
   mse_rsp_if.source rsp_chan
);
   import mse_pkg::*;

   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int WID_W  = CNT_W + 1;
   localparam int SUM_W  = CNT_W + 3;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   // Two memories; the loaded values always land in value_store_mem.
   word_type value_store_mem [MAX_ITEMS];
   word_type merge_scratch_mem [MAX_ITEMS];

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [WID_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             src_scratch_ff, src_scratch_in;

   word_type         out_value_ff, out_value_in;
   logic             out_last_ff, out_last_in;
   logic             out_dropped_ff, out_dropped_in;

   word_type         rd_store0_ff, rd_store1_ff;
   word_type         rd_scratch0_ff, rd_scratch1_ff;

   logic [ADDR_W-1:0] rd_addr0, rd_addr1, wr_addr;
   word_type          wr_data;
   logic              we_store, we_scratch;

   logic             req_fire, rsp_fire;
   word_type         head_a, head_b;
   logic             take_a;
   logic [SUM_W-1:0] lo_plus_w, lo_plus_2w, n_ext;
   logic             pass_over, run_last, merge_done;
   logic [CNT_W-1:0] k_next;

   assign req_chan.ready        = (state_ff == S_LOAD);
   assign rsp_chan.valid        = (state_ff == S_EMIT_OUT);
   assign rsp_chan.sorted_value = out_value_ff;
   assign rsp_chan.last_of_run  = out_last_ff;
   assign rsp_chan.dropped      = out_dropped_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // Run heads come from whichever memory is the source of the current pass.
   assign head_a = src_scratch_ff ? rd_scratch0_ff : rd_store0_ff;
   assign head_b = src_scratch_ff ? rd_scratch1_ff : rd_store1_ff;

   // The left run wins ties, so equal values keep their arrival order.
   assign take_a = (i_ff < mid_ff) && ((j_ff >= hi_ff) || !(head_b < head_a));

   assign lo_plus_w  = SUM_W'(lo_ff) + SUM_W'(width_ff);
   assign lo_plus_2w = lo_plus_w + SUM_W'(width_ff);
   assign n_ext      = SUM_W'(count_ff);
   assign pass_over  = (width_ff >= WID_W'(count_ff));
   assign k_next     = k_ff + CNT_W'(1);
   assign merge_done = (k_next == hi_ff);
   assign run_last   = (hi_ff == count_ff);

   // Memory port steering.
   always_comb begin
      rd_addr0   = (state_ff == S_EMIT_RD) ? k_ff[ADDR_W-1:0] : i_ff[ADDR_W-1:0];
      rd_addr1   = j_ff[ADDR_W-1:0];
      we_store   = 1'b0;
      we_scratch = 1'b0;
      wr_addr    = k_ff[ADDR_W-1:0];
      wr_data    = take_a ? head_a : head_b;
      if (state_ff == S_LOAD) begin
         we_store = req_fire && (count_ff < MAX_CNT);
         wr_addr  = count_ff[ADDR_W-1:0];
         wr_data  = req_chan.value;
      end else if (state_ff == S_MERGE) begin
         we_store   = src_scratch_ff;
         we_scratch = !src_scratch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we_store) begin
         value_store_mem[wr_addr] <= wr_data;
      end
      rd_store0_ff <= value_store_mem[rd_addr0];
      rd_store1_ff <= value_store_mem[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (we_scratch) begin
         merge_scratch_mem[wr_addr] <= wr_data;
      end
      rd_scratch0_ff <= merge_scratch_mem[rd_addr0];
      rd_scratch1_ff <= merge_scratch_mem[rd_addr1];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_fire && req_chan.last_in_set) begin
               state_in = S_PASS;
            end
         end
         S_PASS:   state_in = pass_over ? S_EMIT_RD : S_RUN;
         S_RUN:    state_in = S_READ;
         S_READ:   state_in = S_MERGE;
         S_MERGE: begin
            if (!merge_done) begin
               state_in = S_READ;
            end else if (run_last) begin
               state_in = S_PASS;
            end else begin
               state_in = S_RUN;
            end
         end
         S_EMIT_RD: state_in = S_EMIT_LD;
         S_EMIT_LD: state_in = S_EMIT_OUT;
         S_EMIT_OUT: begin
            if (rsp_fire) begin
               state_in = out_last_ff ? S_LOAD : S_EMIT_RD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      width_in       = width_ff;
      lo_in          = lo_ff;
      mid_in         = mid_ff;
      hi_in          = hi_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      src_scratch_in = src_scratch_ff;
      out_value_in   = out_value_ff;
      out_last_in    = out_last_ff;
      out_dropped_in = out_dropped_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < MAX_CNT) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               width_in       = WID_W'(1);
               lo_in          = '0;
               src_scratch_in = 1'b0;
            end
         end
         S_PASS: begin
            k_in  = '0;
            lo_in = '0;
         end
         S_RUN: begin
            mid_in = (lo_plus_w > n_ext) ? count_ff : lo_plus_w[CNT_W-1:0];
            hi_in  = (lo_plus_2w > n_ext) ? count_ff : lo_plus_2w[CNT_W-1:0];
            i_in   = lo_ff;
            j_in   = (lo_plus_w > n_ext) ? count_ff : lo_plus_w[CNT_W-1:0];
            k_in   = lo_ff;
         end
         S_MERGE: begin
            k_in = k_next;
            if (take_a) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
            if (merge_done) begin
               if (run_last) begin
                  width_in       = width_ff << 1;
                  src_scratch_in = !src_scratch_ff;
               end else begin
                  lo_in = hi_ff;
               end
            end
         end
         S_EMIT_LD: begin
            out_value_in   = src_scratch_ff ? rd_scratch0_ff : rd_store0_ff;
            out_last_in    = (k_next == count_ff);
            out_dropped_in = overflow_ff;
         end
         S_EMIT_OUT: begin
            if (rsp_fire) begin
               k_in = k_next;
               if (out_last_ff) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff       <= width_in;
      lo_ff          <= lo_in;
      mid_ff         <= mid_in;
      hi_ff          <= hi_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      src_scratch_ff <= src_scratch_in;
      out_value_ff   <= out_value_in;
      out_last_ff    <= out_last_in;
      out_dropped_ff <= out_dropped_in;
   end

   // The fill level never passes the store size.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_CNT)
      else $error("value count exceeds store size");

   // Every merge step writes inside the current run.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (k_ff < hi_ff))
      else $error("merge write outside the run");

   // The final result word empties the block and reopens the input.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && out_last_ff) |=> (state_ff == S_LOAD && count_ff == '0 && !overflow_ff))
      else $error("block not emptied after the final result word");

   // A set emits at least one word, and never more than it holds.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_RD) |-> (k_ff < count_ff))
      else $error("result index beyond the set");
endmodule

/* bench/testbench.sv */
// Self-checking bench for merge_sort_engine_unit: sets of signed words go in, and every
// sorted run that comes back is checked against a predictor kept inside the bench.
// Depends on mse_pkg, mse_req_if, mse_rsp_if and merge_sort_engine_unit.
`timescale 1ns / 1ps

module testbench;
   import mse_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      word_type value;
      logic     last_in_set;
   } load_word_type;

   typedef struct {
      word_type sorted_value;
      logic     last_of_run;
      logic     dropped;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mse_req_if req_bus ();
   mse_rsp_if rsp_bus ();

   merge_sort_engine_unit #(.MAX_ITEMS(CAPACITY)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   load_word_type   load_words[$];
   sorted_word_type sorted_expect[$];

   // Predictor state: the values of the open set, kept in ascending order.
   word_type run_sorted[$];
   int       run_fill      = 0;
   bit       run_overflow  = 1'b0;

   load_word_type current_word;
   bit         holding      = 1'b0;
   int         load_gap     = 0;
   int         drain_gap    = 0;
   bit         quiet_loads  = 1'b0;
   bit         quiet_drain  = 1'b0;
   int         fault_count  = 0;
   int         idle_cycles  = 0;

   task automatic flag_error(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Store the word unless the set is full, and on the closing word queue the whole
   // run in ascending order. Equal values stay in arrival order.
   task automatic absorb_word(input load_word_type w);
      int pos;
      if (run_fill < CAPACITY) begin
         pos = run_sorted.size();
         for (int i = 0; i < run_sorted.size(); i++) begin
            if (w.value < run_sorted[i]) begin
               pos = i;
               break;
            end
         end
         run_sorted.insert(pos, w.value);
         run_fill++;
      end else begin
         run_overflow = 1'b1;
      end
      if (w.last_in_set) begin
         for (int k = 0; k < run_sorted.size(); k++) begin
            sorted_expect.push_back('{run_sorted[k], k == run_sorted.size() - 1,
                                      run_overflow});
         end
         run_sorted.delete();
         run_fill = 0;
         run_overflow = 1'b0;
         quiet_loads = ($urandom_range(0, 3) == 0);
      end
   endtask

   task automatic check_result(input sorted_word_type got);
      sorted_word_type want;
      if (sorted_expect.size() == 0) begin
         flag_error($sformatf("Unexpected result word: value %0d last %0b dropped %0b",
                              got.sorted_value, got.last_of_run, got.dropped));
      end else begin
         want = sorted_expect.pop_front();
         if (got.sorted_value !== want.sorted_value || got.last_of_run !== want.last_of_run
             || got.dropped !== want.dropped) begin
            flag_error($sformatf(
               "Mismatch: expected value %0d last %0b dropped %0b, got %0d %0b %0b",
               want.sorted_value, want.last_of_run, want.dropped,
               got.sorted_value, got.last_of_run, got.dropped));
         end
      end
   endtask

   function automatic word_type random_value();
      word_type v;
      case ($urandom_range(0, 3))
         0: begin
            v = word_type'(int'($urandom_range(0, 8)) - 4);
         end
         1: begin
            case ($urandom_range(0, 3))
               0: v = word_type'(32'sh8000_0000);
               1: v = word_type'(32'sh7fff_ffff);
               2: v = word_type'(-1);
               default: v = '0;
            endcase
         end
         default: begin
            v = word_type'($urandom);
         end
      endcase
      return v;
   endfunction

   task automatic add_word(input word_type v, input bit last);
      load_words.push_back('{v, last});
   endtask

   task automatic add_random_set(input int n);
      for (int i = 0; i < n; i++) begin
         add_word(random_value(), i == n - 1);
      end
   endtask

   // Input side: each word waits a random gap, then stays valid until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         holding = 1'b0;
         load_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_word(current_word);
            load_gap = quiet_loads ? 0 : $urandom_range(0, 19);
            holding = 1'b0;
         end
         if (!holding) begin
            if (load_gap > 0) begin
               load_gap--;
               req_bus.valid <= 1'b0;
            end else if (load_words.size() > 0) begin
               current_word = load_words.pop_front();
               req_bus.value <= current_word.value;
               req_bus.last_in_set <= current_word.last_in_set;
               req_bus.valid <= 1'b1;
               holding = 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result side: after each word taken, ready may drop for a random stall, unless the run is quiet.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         drain_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result('{rsp_bus.sorted_value, rsp_bus.last_of_run, rsp_bus.dropped});
            if (rsp_bus.last_of_run) begin
               quiet_drain = ($urandom_range(0, 3) == 0);
            end
            drain_gap = quiet_drain ? 0 : $urandom_range(0, 19);
         end
         if (drain_gap > 0) begin
            drain_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_words;
      int set_size;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.last_in_set = 1'b0;
      rsp_bus.ready = 1'b0;

      // Directed sets: single values at both extremes, mixed extremes with a
      // repeated minus one, all-equal values, a descending run, alternating bits.
      add_word(word_type'(32'sh8000_0000), 1'b1);
      add_word(word_type'(32'sh7fff_ffff), 1'b1);
      add_word('0, 1'b0);
      add_word(word_type'(-1), 1'b0);
      add_word(word_type'(1), 1'b0);
      add_word(word_type'(32'sh7fff_ffff), 1'b0);
      add_word(word_type'(32'sh8000_0000), 1'b0);
      add_word(word_type'(-1), 1'b1);
      for (int i = 0; i < 3; i++) begin
         add_word(word_type'(5), i == 2);
      end
      for (int i = 4; i >= -2; i--) begin
         add_word(word_type'(i), i == -2);
      end
      add_word(word_type'(32'sh5555_5555), 1'b0);
      add_word(word_type'(32'shAAAA_AAAA), 1'b1);

      // A set that fills the store exactly, then one whose tail, including the
      // closing word, arrives while the store is full.
      add_random_set(CAPACITY);
      add_random_set(CAPACITY + 3);
      random_words = 2 * CAPACITY + 3;
      while (random_words < 2 * CAPACITY + 12) begin
         set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30)
                                                 : $urandom_range(1, 10);
         add_random_set(set_size);
         random_words += set_size;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (load_words.size() > 0 || holding || sorted_expect.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sorted_expect.size() > 0) begin
         flag_error($sformatf("%0d expected result words never arrived",
                              sorted_expect.size()));
      end
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/mse_pkg.sv
rtl/mse_req_if.sv
rtl/mse_rsp_if.sv
rtl/merge_sort_engine_unit.sv
bench/testbench.sv
